// ===== rtl/onewire_temp_sensor_master_macros.svh =====
// Assertion macros shared by the one-wire temperature sensor master.
`ifndef ONEWIRE_TEMP_SENSOR_MASTER_MACROS_SVH
`define ONEWIRE_TEMP_SENSOR_MASTER_MACROS_SVH

`ifndef SYNTHESIS
`define OTS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("Assertion failed on the one-wire master.");
`define OTS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("Forbidden condition seen on the one-wire master.");
`else
`define OTS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define OTS_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/ots_pkg.sv =====
// Package with types, codes and timing constants of the one-wire temperature master.
`timescale 1ns / 1ps
package ots_pkg;

    localparam int TICK_W = 9;
    localparam int TEMP_W = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_CONVERT = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_NO_PRESENCE = 2'd1;
    localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOWER_LIMIT = 1'b1;

    localparam logic signed [TEMP_W-1:0] UPPER_LIMIT_RESET = 16'sd2000;
    localparam logic signed [TEMP_W-1:0] LOWER_LIMIT_RESET = -16'sd880;
    localparam logic signed [TEMP_W-1:0] NO_PRESENCE_TEMP = -16'sd16;

    localparam logic [TICK_W-1:0] RESET_LOW_TICKS = 9'd480;
    localparam logic [TICK_W-1:0] RST_WAIT_TICKS = 9'd40;
    localparam logic [TICK_W-1:0] POLL_TICKS = 9'd10;
    localparam logic [TICK_W-1:0] PRES_WAIT_TICKS = 9'd240;
    localparam logic [TICK_W-1:0] SLOT_TICKS = 9'd41;
    localparam logic [TICK_W-1:0] READ_LOW_END = 9'd3;
    localparam logic [TICK_W-1:0] READ_HIGH_END = 9'd8;
    localparam logic [TICK_W-1:0] READ_RELEASE_END = 9'd11;
    localparam logic [TICK_W-1:0] READ_SAMPLE_TICK = 9'd9;
    localparam logic [3:0] PRESENCE_POLLS = 4'd10;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_CONVERT,
        KIND_READ,
        KIND_IGNORE
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_POLL,
        PH_PRES_WAIT,
        PH_WRITE,
        PH_READ
    } t_phase;

    typedef struct packed {
        t_kind kind;
        logic  line_sample;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic                     line_output_enable;
        logic                     line_level;
        logic                     busy_res;
        logic                     done_res;
        logic [1:0]               status;
        logic signed [TEMP_W-1:0] temperature;
    } t_result;

endpackage

// ===== rtl/ots_ifs.sv =====
// Channel interfaces for items, results and register writes.
`timescale 1ns / 1ps
interface ots_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       line_sample;
    modport source(output valid, output mode, output line_sample, input ready);
    modport sink(input valid, input mode, input line_sample, output ready);
endinterface

interface ots_result_if;
    import ots_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     line_output_enable;
    logic                     line_level;
    logic                     busy_res;
    logic                     done_res;
    logic [1:0]               status;
    logic signed [TEMP_W-1:0] temperature;
    modport source(output valid, output line_output_enable, output line_level,
                   output busy_res, output done_res, output status, output temperature,
                   input ready);
    modport sink(input valid, input line_output_enable, input line_level,
                 input busy_res, input done_res, input status, input temperature,
                 output ready);
endinterface

interface ots_cfg_if;
    import ots_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [TEMP_W-1:0]      wr_data;
    modport source(output valid, output wr_index, output wr_data, input ready);
    modport sink(input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== rtl/onewire_temp_sensor_master.sv =====
// Top level of the one-wire bus master for a temperature sensor.
//
// Each word on i_item is either a one-microsecond tick carrying the sampled
// bus level, a start-conversion command or a read-temperature command (any other mode is ignored).
// Every accepted word yields exactly one word on o_result, in order, giving
// the line drive that holds until the next tick plus busy, done and status.
// Limit registers are written through i_cfg, which is always ready.
// A word flows from the front end through a four-entry queue to the bus
// engine, which updates its state and fills the output register.
// A word is stored in the queue and its result then in the output register;
// one word per cycle is sustained while o_result.ready stays high, and the
// per-word state update in the engine sets that rate.
// The output register holds a result while o_result.ready is low; the queue
// then fills and i_item.ready drops once it is full.
// Synchronous reset returns the sequencer to idle, clears the queue and the
// output valid flag, and restores the default limits.
`timescale 1ns / 1ps
`include "onewire_temp_sensor_master_macros.svh"
module onewire_temp_sensor_master (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ots_item_if.sink     i_item,
    ots_cfg_if.sink      i_cfg,
    ots_result_if.source o_result
);
    import ots_pkg::*;

    t_item         front_item;
    t_item         queue_item;
    t_queue_status q_status;
    logic          push;
    logic          pop;

    ots_front u_front (
        .i_item     (i_item),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (front_item)
    );

    ots_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    ots_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (queue_item),
        .i_q_status (q_status),
        .o_pop      (pop),
        .i_cfg      (i_cfg),
        .o_result   (o_result)
    );

    `OTS_ASSERT_NEVER(a_queue_full_empty, i_clk, i_rst_n, q_status.full && q_status.empty)
    `OTS_ASSERT_IMPLIES(a_done_not_busy, i_clk, i_rst_n, o_result.valid && o_result.done_res, !o_result.busy_res)
    `OTS_ASSERT_IMPLIES(a_released_low, i_clk, i_rst_n, o_result.valid && !o_result.line_output_enable, !o_result.line_level)
    `OTS_ASSERT_IMPLIES(a_status_on_done, i_clk, i_rst_n, o_result.valid && o_result.status != STATUS_OK, o_result.done_res)
endmodule

// ===== rtl/ots_front.sv =====
// Front end: accepts input words and classifies them for the queue.
`timescale 1ns / 1ps
module ots_front (
    ots_item_if.sink               i_item,
    input  ots_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output ots_pkg::t_item         o_item
);
    import ots_pkg::*;

    assign i_item.ready = !i_q_status.full;
    assign o_push = i_item.valid && i_item.ready;

    always_comb begin
        o_item.line_sample = i_item.line_sample;
        unique case (i_item.mode)
            MODE_TICK: begin
                o_item.kind = KIND_TICK;
            end
            MODE_CONVERT: begin
                o_item.kind = KIND_CONVERT;
            end
            MODE_READ: begin
                o_item.kind = KIND_READ;
            end
            default: begin
                o_item.kind = KIND_IGNORE;
            end
        endcase
    end
endmodule

// ===== rtl/ots_queue.sv =====
// Short queue of classified words between the front end and the bus engine.
`timescale 1ns / 1ps
module ots_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ots_pkg::t_item         i_item,
    input  logic                   i_pop,
    output ots_pkg::t_item         o_item,
    output ots_pkg::t_queue_status o_status
);
    import ots_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_status.full = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop = i_pop && !o_status.empty;
    assign o_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/ots_engine.sv =====
// Bus engine: runs the reset, command and read sequences and registers each result.
`timescale 1ns / 1ps
module ots_engine (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ots_pkg::t_item         i_item,
    input  ots_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    ots_cfg_if.sink                i_cfg,
    ots_result_if.source           o_result
);
    import ots_pkg::*;

    t_phase                   r_phase;
    t_phase                   n_phase;
    logic [TICK_W-1:0]        r_tick;
    logic [TICK_W-1:0]        n_tick;
    logic [2:0]               r_bit;
    logic [2:0]               n_bit;
    logic [1:0]               r_byte;
    logic [1:0]               n_byte;
    logic [3:0]               r_poll;
    logic [3:0]               n_poll;
    logic [7:0]               r_shift;
    logic [7:0]               n_shift;
    logic [7:0]               r_raw_low;
    logic [7:0]               n_raw_low;
    logic                     r_cmd_read;
    logic                     n_cmd_read;
    logic signed [TEMP_W-1:0] r_last_good;
    logic signed [TEMP_W-1:0] n_last_good;
    logic signed [TEMP_W-1:0] r_upper;
    logic signed [TEMP_W-1:0] r_lower;
    logic                     r_out_valid;
    t_result                  r_result;
    t_result                  n_result;
    logic [TICK_W-1:0]        tick_inc;
    logic [1:0]               byte_inc;
    logic signed [TEMP_W-1:0] reading;

    assign o_pop = !i_q_status.empty && (!r_out_valid || o_result.ready);
    assign i_cfg.ready = 1'b1;

    assign o_result.valid = r_out_valid;
    assign o_result.line_output_enable = r_result.line_output_enable;
    assign o_result.line_level = r_result.line_level;
    assign o_result.busy_res = r_result.busy_res;
    assign o_result.done_res = r_result.done_res;
    assign o_result.status = r_result.status;
    assign o_result.temperature = r_result.temperature;

    always_comb begin
        n_phase = r_phase;
        n_tick = r_tick;
        n_bit = r_bit;
        n_byte = r_byte;
        n_poll = r_poll;
        n_shift = r_shift;
        n_raw_low = r_raw_low;
        n_cmd_read = r_cmd_read;
        n_last_good = r_last_good;
        n_result.done_res = 1'b0;
        n_result.status = STATUS_OK;
        n_result.temperature = '0;
        tick_inc = r_tick + 1'b1;
        byte_inc = r_byte + 1'b1;
        reading = {r_shift, r_raw_low};

        unique case (i_item.kind)
            KIND_CONVERT, KIND_READ: begin
                if (r_phase == PH_IDLE) begin
                    n_cmd_read = (i_item.kind == KIND_READ);
                    n_phase = PH_RST_LOW;
                    n_tick = '0;
                    n_poll = '0;
                    n_bit = '0;
                    n_byte = '0;
                end
            end
            KIND_TICK: begin
                unique case (r_phase)
                    PH_IDLE: begin
                    end
                    PH_RST_LOW: begin
                        n_tick = tick_inc;
                        if (tick_inc >= RESET_LOW_TICKS) begin
                            n_phase = PH_RST_WAIT;
                            n_tick = '0;
                        end
                    end
                    PH_RST_WAIT, PH_POLL: begin
                        n_tick = tick_inc;
                        if (r_phase == PH_POLL && tick_inc >= POLL_TICKS
                                && r_poll >= PRESENCE_POLLS) begin
                            n_phase = PH_IDLE;
                            n_tick = '0;
                            n_result.done_res = 1'b1;
                            n_result.status = STATUS_NO_PRESENCE;
                            n_result.temperature = NO_PRESENCE_TEMP;
                        end else if ((r_phase == PH_RST_WAIT && tick_inc >= RST_WAIT_TICKS)
                                || (r_phase == PH_POLL && tick_inc >= POLL_TICKS)) begin
                            n_tick = '0;
                            if (!i_item.line_sample) begin
                                n_phase = PH_PRES_WAIT;
                            end else begin
                                n_poll = r_poll + 1'b1;
                                n_phase = PH_POLL;
                            end
                        end
                    end
                    PH_PRES_WAIT: begin
                        n_tick = tick_inc;
                        if (tick_inc >= PRES_WAIT_TICKS) begin
                            n_phase = PH_WRITE;
                            n_tick = '0;
                            n_bit = '0;
                            n_byte = '0;
                            n_shift = CMD_SKIP_ROM;
                        end
                    end
                    PH_WRITE: begin
                        n_tick = tick_inc;
                        if (tick_inc >= SLOT_TICKS) begin
                            n_tick = '0;
                            n_shift = r_shift >> 1;
                            n_bit = r_bit + 1'b1;
                            if (r_bit == 3'd7) begin
                                n_byte = byte_inc;
                                if (byte_inc >= 2'd2) begin
                                    n_byte = '0;
                                    n_shift = '0;
                                    if (!r_cmd_read) begin
                                        n_phase = PH_IDLE;
                                        n_result.done_res = 1'b1;
                                    end else begin
                                        n_phase = PH_READ;
                                    end
                                end else begin
                                    n_shift = r_cmd_read ? CMD_READ_SCRATCH : CMD_CONVERT;
                                end
                            end
                        end
                    end
                    PH_READ: begin
                        n_tick = tick_inc;
                        if (tick_inc == READ_SAMPLE_TICK) begin
                            n_shift = {i_item.line_sample, r_shift[7:1]};
                        end
                        if (tick_inc >= SLOT_TICKS) begin
                            n_tick = '0;
                            n_bit = r_bit + 1'b1;
                            if (r_bit == 3'd7) begin
                                n_shift = '0;
                                if (r_byte == 2'd0) begin
                                    n_raw_low = r_shift;
                                    n_byte = 2'd1;
                                end else begin
                                    n_byte = '0;
                                    n_phase = PH_IDLE;
                                    n_result.done_res = 1'b1;
                                    if (reading < r_upper && reading > r_lower) begin
                                        n_last_good = reading;
                                        n_result.temperature = reading;
                                    end else begin
                                        n_result.status = STATUS_OUT_OF_RANGE;
                                        n_result.temperature = r_last_good;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        n_result.line_output_enable = 1'b1;
        n_result.line_level = 1'b1;
        unique case (n_phase)
            PH_RST_LOW: begin
                n_result.line_level = 1'b0;
            end
            PH_RST_WAIT, PH_POLL, PH_PRES_WAIT: begin
                n_result.line_output_enable = 1'b0;
                n_result.line_level = 1'b0;
            end
            PH_WRITE: begin
                n_result.line_level = (n_tick == '0) ? 1'b0 : n_shift[0];
            end
            PH_READ: begin
                if (n_tick < READ_LOW_END) begin
                    n_result.line_level = 1'b0;
                end else if (n_tick >= READ_HIGH_END && n_tick < READ_RELEASE_END) begin
                    n_result.line_output_enable = 1'b0;
                    n_result.line_level = 1'b0;
                end
            end
            default: begin
            end
        endcase
        n_result.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick <= '0;
            r_bit <= '0;
            r_byte <= '0;
            r_poll <= '0;
            r_shift <= '0;
            r_raw_low <= '0;
            r_cmd_read <= 1'b0;
            r_last_good <= '0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_tick <= n_tick;
            r_bit <= n_bit;
            r_byte <= n_byte;
            r_poll <= n_poll;
            r_shift <= n_shift;
            r_raw_low <= n_raw_low;
            r_cmd_read <= n_cmd_read;
            r_last_good <= n_last_good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= UPPER_LIMIT_RESET;
            r_lower <= LOWER_LIMIT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.wr_index)
                CFG_UPPER_LIMIT: begin
                    r_upper <= i_cfg.wr_data;
                end
                CFG_LOWER_LIMIT: begin
                    r_lower <= i_cfg.wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end
endmodule
